/* rtl/core/csfwq_pkg.sv */
package csfwq_pkg;

  localparam int QueueDepth   = 16;
  localparam int ThreadIdBits = 8;
  localparam int TidFieldW    = 8;
  localparam int CountFieldW  = 16;
  localparam int CountW       = 18;
  localparam int PtrW         = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int OccW         = $clog2(QueueDepth + 1);
  localparam logic [CountW-1:0] CountMax = {1'b0, {(CountW-1){1'b1}}};

  typedef enum logic [1:0] {
    OP_OPEN   = 2'd0,
    OP_WAIT   = 2'd1,
    OP_SIGNAL = 2'd2,
    OP_CLOSE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_CLOSED = 2'd1,
    ST_FULL   = 2'd2,
    ST_SAT    = 2'd3
  } status_e;

  typedef struct packed {
    op_e                     op;
    logic [ThreadIdBits-1:0] tid;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic                 blocked;
    logic                 released_valid;
    logic [TidFieldW-1:0] released_thread;
    logic                 last;
  } rsp_t;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

endpackage

/* rtl/core/csfwq_if.sv */
interface csfwq_req_if;
  import csfwq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [TidFieldW-1:0] thread_id;
  modport source (output valid, req_type, thread_id, input ready);
  modport sink   (input valid, req_type, thread_id, output ready);
endinterface

interface csfwq_rsp_if;
  import csfwq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic                 blocked;
  logic                 released_valid;
  logic [TidFieldW-1:0] released_thread;
  logic                 last;
  modport source (output valid, status, blocked, released_valid, released_thread, last,
                  input ready);
  modport sink   (input valid, status, blocked, released_valid, released_thread, last,
                  output ready);
endinterface

interface csfwq_cfg_if;
  import csfwq_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CountFieldW-1:0] initial_count;
  modport source (output valid, initial_count, input ready);
  modport sink   (input valid, initial_count, output ready);
endinterface

/* rtl/core/csfwq_front.sv */
module csfwq_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    req_type_i,
  input  logic [csfwq_pkg::TidFieldW-1:0] thread_id_i,
  output logic                          req_valid_o,
  input  logic                          req_ready_i,
  output csfwq_pkg::req_t               req_o
);
  import csfwq_pkg::*;

  // two-entry queue of classified requests
  req_t       ent_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  req_t       cls;
  logic       push, pop;

  always_comb begin
    cls.op  = op_e'(req_type_i);
    cls.tid = thread_id_i[ThreadIdBits-1:0];
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = ent_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = req_valid_o && req_ready_i;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= cls;
    end
  end

endmodule

/* rtl/core/csfwq_back.sv */
module csfwq_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [csfwq_pkg::CountFieldW-1:0]    init_count_i,
  input  logic                                 req_valid_i,
  output logic                                 req_ready_o,
  input  csfwq_pkg::req_t                      req_i,
  output logic                                 rsp_valid_o,
  input  logic                                 rsp_ready_i,
  output csfwq_pkg::rsp_t                      rsp_o
);
  import csfwq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_POP, S_DRAIN} state_e;

  state_e                  state_q, state_d;
  logic [CountW-1:0]       count_q, count_d;
  logic                    open_q, open_d;
  logic [PtrW-1:0]         head_q, head_d, tail_q, tail_d;
  logic [OccW-1:0]         occ_q, occ_d;
  logic                    rsp_valid_q, rsp_valid_d;
  rsp_t                    rsp_q, rsp_d;

  logic [ThreadIdBits-1:0] mem_q [QueueDepth];
  logic [ThreadIdBits-1:0] rd_q;
  logic                    mem_we, mem_re;
  logic                    out_free, cnt_le0, cnt_neg;

  assign out_free = !rsp_valid_q || rsp_ready_i;
  assign cnt_neg  = count_q[CountW-1];
  assign cnt_le0  = cnt_neg || (count_q == '0);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    open_d      = open_q;
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    rsp_d       = rsp_q;
    req_ready_o = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i && out_free) begin
          req_ready_o = 1'b1;
          rsp_valid_d = 1'b1;
          rsp_d       = '{status: ST_OK, blocked: 1'b0, released_valid: 1'b0,
                          released_thread: '0, last: 1'b1};
          if (req_i.op == OP_OPEN) begin
            count_d = CountW'(init_count_i);
            head_d  = '0;
            tail_d  = '0;
            occ_d   = '0;
            open_d  = 1'b1;
          end else if (!open_q) begin
            rsp_d.status = ST_CLOSED;
          end else begin
            unique case (req_i.op)
              OP_WAIT: begin
                if (cnt_le0 && (occ_q == OccW'(QueueDepth))) begin
                  rsp_d.status = ST_FULL;
                end else begin
                  count_d = count_q - CountW'(1);
                  if (cnt_le0) begin
                    mem_we        = 1'b1;
                    tail_d        = next_ptr(tail_q);
                    occ_d         = occ_q + OccW'(1);
                    rsp_d.blocked = 1'b1;
                  end
                end
              end
              OP_SIGNAL: begin
                if (count_q == CountMax) begin
                  rsp_d.status = ST_SAT;
                end else begin
                  count_d = count_q + CountW'(1);
                  // still at most zero after the increment: wake the oldest waiter
                  if (cnt_neg && (occ_q != '0)) begin
                    mem_re      = 1'b1;
                    head_d      = next_ptr(head_q);
                    occ_d       = occ_q - OccW'(1);
                    rsp_valid_d = 1'b0;
                    state_d     = S_POP;
                  end
                end
              end
              default: begin
                if (occ_q == '0) begin
                  count_d = '0;
                  open_d  = 1'b0;
                  head_d  = '0;
                  tail_d  = '0;
                end else begin
                  mem_re      = 1'b1;
                  head_d      = next_ptr(head_q);
                  occ_d       = occ_q - OccW'(1);
                  rsp_valid_d = 1'b0;
                  state_d     = S_DRAIN;
                end
              end
            endcase
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          rsp_valid_d = 1'b1;
          rsp_d       = '{status: ST_OK, blocked: 1'b0, released_valid: 1'b1,
                          released_thread: TidFieldW'(rd_q), last: 1'b1};
          state_d     = S_IDLE;
        end
      end
      default: begin
        if (out_free) begin
          rsp_valid_d = 1'b1;
          rsp_d       = '{status: ST_OK, blocked: 1'b0, released_valid: 1'b1,
                          released_thread: TidFieldW'(rd_q), last: (occ_q == '0)};
          if (occ_q != '0) begin
            mem_re = 1'b1;
            head_d = next_ptr(head_q);
            occ_d  = occ_q - OccW'(1);
          end else begin
            count_d = '0;
            open_d  = 1'b0;
            head_d  = '0;
            tail_d  = '0;
            state_d = S_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      open_q      <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      open_q      <= open_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      rsp_valid_q <= rsp_valid_d;
      rsp_q       <= rsp_d;
    end
  end

  // waiter store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[tail_q] <= req_i.tid;
    end
    if (mem_re) begin
      rd_q <= mem_q[head_q];
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

/* rtl/core/counting_semaphore_fifo_waitq.sv */
// Counting semaphore with a FIFO of blocked thread ids.
// Channels: req_i (req_type, thread_id), rsp_o (status, blocked,
// released_valid, released_thread, last) and cfg_i, which writes
// initial_count; cfg_i is always ready and must only be written while idle.
// A request enters a two-entry queue in the front end; the back end executes
// it and places each result in an output register, from which rsp_o.valid
// is driven. Open, wait, a refused request and a signal that wakes no one
// load that register straight from S_IDLE; a signal that wakes a waiter
// first passes through S_POP, and a close that releases any through S_DRAIN,
// as the waiter store has a registered read port. A close with n waiters
// gives n results, the last one flagged.
// When rsp_o stalls the back end holds its result and stops; the front
// queue still takes up to two further items before req_i.ready drops.
// Reset (async, active low) leaves the semaphore closed with count zero,
// an empty wait queue and initial_count zero.
module counting_semaphore_fifo_waitq (
  input logic         clk_i,
  input logic         rst_ni,
  csfwq_cfg_if.sink   cfg_i,
  csfwq_req_if.sink   req_i,
  csfwq_rsp_if.source rsp_o
);
  import csfwq_pkg::*;

  logic [CountFieldW-1:0] init_count_q;
  logic                   req_valid, req_ready;
  req_t                   req;
  rsp_t                   rsp;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_count_q <= '0;
    end else if (cfg_i.valid) begin
      init_count_q <= cfg_i.initial_count;
    end
  end

  csfwq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .req_type_i  (req_i.req_type),
    .thread_id_i (req_i.thread_id),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready),
    .req_o       (req)
  );

  csfwq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .init_count_i (init_count_q),
    .req_valid_i  (req_valid),
    .req_ready_o  (req_ready),
    .req_i        (req),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_o        (rsp)
  );

  assign rsp_o.status          = rsp.status;
  assign rsp_o.blocked         = rsp.blocked;
  assign rsp_o.released_valid  = rsp.released_valid;
  assign rsp_o.released_thread = rsp.released_thread;
  assign rsp_o.last            = rsp.last;

endmodule

/* dv/csfwq_checker.sv */
`timescale 1ns / 100ps

module csfwq_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  csfwq_req_if  req_mon,
  csfwq_rsp_if  rsp_mon,
  csfwq_cfg_if  cfg_mon,
  output int    fail_cnt_o,
  output int    owed_o,
  output int    replies_o,
  output int    wakes_o,
  output int    blocks_o,
  output int    refusals_o
);
  import csfwq_pkg::*;

  logic signed [CountW-1:0] sem_count;
  logic                     sem_live;
  logic [CountFieldW-1:0]   open_count;
  logic [ThreadIdBits-1:0]  sleepers[$];
  rsp_t                     owed_replies[$];

  initial begin
    fail_cnt_o = 0;
    owed_o     = 0;
    replies_o  = 0;
    wakes_o    = 0;
    blocks_o   = 0;
    refusals_o = 0;
  end

  function automatic void owe(status_e st, logic blk, logic rv,
                              logic [TidFieldW-1:0] tid, logic lst);
    rsp_t r;
    r.status          = st;
    r.blocked         = blk;
    r.released_valid  = rv;
    r.released_thread = rv ? tid : '0;
    r.last            = lst;
    owed_replies.push_back(r);
  endfunction

  task automatic serve_request(op_e op, logic [TidFieldW-1:0] tid_in);
    logic [ThreadIdBits-1:0] tid;
    logic [ThreadIdBits-1:0] woken;
    tid = tid_in[ThreadIdBits-1:0];
    if (op == OP_OPEN) begin
      sem_count = CountW'(open_count);
      sleepers.delete();
      sem_live  = 1'b1;
      owe(ST_OK, 1'b0, 1'b0, '0, 1'b1);
    end else if (!sem_live) begin
      owe(ST_CLOSED, 1'b0, 1'b0, '0, 1'b1);
    end else begin
      case (op)
        OP_WAIT: begin
          if (sem_count < 1) begin
            if (sleepers.size() >= QueueDepth) begin
              owe(ST_FULL, 1'b0, 1'b0, '0, 1'b1);
            end else begin
              sem_count = sem_count - 1;
              sleepers.push_back(tid);
              owe(ST_OK, 1'b1, 1'b0, '0, 1'b1);
            end
          end else begin
            sem_count = sem_count - 1;
            owe(ST_OK, 1'b0, 1'b0, '0, 1'b1);
          end
        end
        OP_SIGNAL: begin
          if (int'(sem_count) >= int'(CountMax)) begin
            owe(ST_SAT, 1'b0, 1'b0, '0, 1'b1);
          end else begin
            sem_count = sem_count + 1;
            if (sem_count < 1 && sleepers.size() > 0) begin
              woken = sleepers.pop_front();
              owe(ST_OK, 1'b0, 1'b1, TidFieldW'(woken), 1'b1);
            end else begin
              owe(ST_OK, 1'b0, 1'b0, '0, 1'b1);
            end
          end
        end
        default: begin
          // close: every waiter released in queue order, last on the final one
          if (sleepers.size() == 0) begin
            owe(ST_OK, 1'b0, 1'b0, '0, 1'b1);
          end else begin
            while (sleepers.size() > 0) begin
              woken = sleepers.pop_front();
              owe(ST_OK, 1'b0, 1'b1, TidFieldW'(woken), sleepers.size() == 0);
            end
          end
          sem_count = '0;
          sem_live  = 1'b0;
        end
      endcase
    end
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_cnt_o++;
    end
  endtask

  task automatic check_reply();
    rsp_t want;
    replies_o++;
    if (rsp_mon.released_valid) wakes_o++;
    if (rsp_mon.blocked) blocks_o++;
    if (rsp_mon.status != ST_OK) refusals_o++;
    if (owed_replies.size() == 0) begin
      $error("result item with no request outstanding");
      fail_cnt_o++;
    end else begin
      want = owed_replies.pop_front();
      check_field("status", want.status, rsp_mon.status);
      check_field("blocked", want.blocked, rsp_mon.blocked);
      check_field("released_valid", want.released_valid, rsp_mon.released_valid);
      check_field("released_thread", want.released_thread, rsp_mon.released_thread);
      check_field("last", want.last, rsp_mon.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sem_count  = '0;
      sem_live   = 1'b0;
      open_count = '0;
      sleepers.delete();
      owed_replies.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) open_count = cfg_mon.initial_count;
      if (req_mon.valid && req_mon.ready) begin
        serve_request(op_e'(req_mon.req_type), req_mon.thread_id);
      end
      if (rsp_mon.valid && rsp_mon.ready) check_reply();
    end
    owed_o = owed_replies.size();
  end

endmodule

/* dv/tb_counting_semaphore_fifo_waitq.sv */
`timescale 1ns / 100ps

module tb_counting_semaphore_fifo_waitq;
  import csfwq_pkg::*;

  localparam int CycleLimit   = 1_000_000;
  localparam int SettleCycles = 24;
  localparam int StallCycles  = 300;
  localparam int RandomItems  = 108;

  logic clk;
  logic rst_n;
  int   src_idle_pct = 0;
  int   snk_idle_pct = 0;
  logic snk_hold     = 1'b0;
  int   cycles       = 0;
  int   items_sent   = 0;
  int   rand_base;
  int   fail_cnt, owed, replies, wakes, blocks, refusals;

  csfwq_req_if req_if ();
  csfwq_rsp_if rsp_if ();
  csfwq_cfg_if cfg_if ();

  counting_semaphore_fifo_waitq uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  csfwq_checker chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_mon    (req_if),
    .rsp_mon    (rsp_if),
    .cfg_mon    (cfg_if),
    .fail_cnt_o (fail_cnt),
    .owed_o     (owed),
    .replies_o  (replies),
    .wakes_o    (wakes),
    .blocks_o   (blocks),
    .refusals_o (refusals)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[counting_semaphore_fifo_waitq] ERROR");
      $finish;
    end
  end

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_if.ready <= !snk_hold && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  function automatic logic [TidFieldW-1:0] rand_tid();
    return TidFieldW'($urandom_range(255));
  endfunction

  task automatic send_req(op_e op, logic [TidFieldW-1:0] tid);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.req_type  <= op;
    req_if.thread_id <= tid;
    do @(posedge clk); while (!req_if.ready);
    items_sent++;
  endtask

  // returns on a rising edge once every outstanding result is back
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(negedge clk); while (owed != 0);
    @(posedge clk);
  endtask

  task automatic set_init_count(logic [CountFieldW-1:0] value);
    drain();
    cfg_if.valid         <= 1'b1;
    cfg_if.initial_count <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // queue filled to the brim, two refused waits, then a close that wakes all
  task automatic fill_and_close();
    set_init_count('0);
    send_req(OP_OPEN, rand_tid());
    repeat (QueueDepth + 1) send_req(OP_WAIT, rand_tid());
    send_req(OP_SIGNAL, rand_tid());
    send_req(OP_WAIT, rand_tid());
    send_req(OP_WAIT, rand_tid());
    send_req(OP_CLOSE, rand_tid());
  endtask

  task automatic run_session(int n_ops);
    int pick;
    logic [CountFieldW-1:0] start_count;
    pick = $urandom_range(9);
    if (pick == 0) start_count = '0;
    else if (pick == 1) start_count = '1;
    else if (pick == 2) start_count = CountFieldW'($urandom_range(65535));
    else start_count = CountFieldW'($urandom_range(4));
    set_init_count(start_count);
    send_req(OP_OPEN, rand_tid());
    repeat (n_ops) begin
      pick = $urandom_range(99);
      if (pick < 45) send_req(OP_WAIT, rand_tid());
      else if (pick < 85) send_req(OP_SIGNAL, rand_tid());
      else if (pick < 90) send_req(OP_OPEN, rand_tid());
      else if (pick < 95) send_req(OP_CLOSE, rand_tid());
      else send_req(op_e'($urandom_range(3)), rand_tid());
    end
    if ($urandom_range(3) != 0) send_req(OP_CLOSE, rand_tid());
  endtask

  initial begin
    req_if.valid         <= 1'b0;
    req_if.req_type      <= OP_OPEN;
    req_if.thread_id     <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.initial_count <= '0;
    rst_n                <= 1'b0;
    src_idle_pct = 9;
    snk_idle_pct = 78;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // closed after reset: all refused
    send_req(OP_WAIT, 8'hFF);
    send_req(OP_SIGNAL, 8'h00);
    send_req(OP_CLOSE, 8'h55);

    set_init_count('0);
    send_req(OP_OPEN, 8'h00);
    send_req(OP_WAIT, 8'hFF);
    send_req(OP_WAIT, 8'h00);
    send_req(OP_SIGNAL, 8'h11);
    send_req(OP_SIGNAL, 8'h22);
    send_req(OP_SIGNAL, 8'h33);
    send_req(OP_WAIT, 8'h5A);
    // reopen drops the queued waiter silently
    send_req(OP_WAIT, 8'hA5);
    send_req(OP_OPEN, 8'h0F);
    send_req(OP_SIGNAL, 8'hF0);
    send_req(OP_CLOSE, 8'h01);
    send_req(OP_CLOSE, 8'h02);

    set_init_count(16'd2);
    send_req(OP_OPEN, 8'h80);
    send_req(OP_WAIT, 8'h3C);
    send_req(OP_WAIT, 8'hC3);
    send_req(OP_WAIT, 8'h81);
    send_req(OP_WAIT, 8'h7E);
    send_req(OP_CLOSE, 8'h44);

    rand_base = items_sent;
    fill_and_close();
    while (items_sent < rand_base + RandomItems / 3) run_session($urandom_range(4, 14));

    drain();
    src_idle_pct = 78;
    snk_idle_pct = 9;
    while (items_sent < rand_base + 2 * RandomItems / 3) run_session($urandom_range(4, 14));

    drain();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    fork
      begin
        snk_hold <= 1'b1;
        repeat (StallCycles) @(posedge clk);
        snk_hold <= 1'b0;
      end
    join_none
    fill_and_close();
    while (items_sent < rand_base + RandomItems) run_session($urandom_range(4, 14));

    req_if.valid <= 1'b0;
    do @(negedge clk); while (owed != 0);
    repeat (SettleCycles) @(negedge clk);

    $display("Run covered %0d requests and %0d results: %0d wakes, %0d blocked waits,",
             items_sent, replies, wakes, blocks);
    $display("  %0d refusals (closed semaphore or full queue); %0d failures.",
             refusals, fail_cnt);
    if (fail_cnt == 0 && owed == 0) begin
      $display("[counting_semaphore_fifo_waitq] OK");
    end else begin
      $display("[counting_semaphore_fifo_waitq] ERROR");
    end
    $finish;
  end

endmodule
